// ----- design/pif_pkg.sv -----
// Shared types and constants for the aligned-PER integer field encoder.
package pif_pkg;

    // Field kinds carried by the func input
    typedef enum logic [2:0] {
        FUNC_BOOL    = 3'd0,
        FUNC_CONS    = 3'd1,
        FUNC_UNCONS  = 3'd2,
        FUNC_EXT     = 3'd3,
        FUNC_SEMI    = 3'd4,
        FUNC_NSMALL  = 3'd5,
        FUNC_LENGTH  = 3'd6,
        FUNC_FLUSH   = 3'd7
    } func_t;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam int unsigned PRE_W   = 9;   // leading bit-field, up to 9 bits
    localparam int unsigned BODY_W  = 40;  // aligned octets, up to 5
    localparam int unsigned BUF_W   = 56;  // head octets plus body octets

    // One classified field, ready for the packer
    typedef struct packed {
        logic              err;     // oversized length determinant
        logic [PRE_W-1:0]  pre;     // unaligned bits, right-justified
        logic [3:0]        pre_len; // 0..9
        logic              align;   // pad to an octet boundary after pre
        logic [BODY_W-1:0] body;    // octets, left-justified
        logic [2:0]        nbytes;  // 0..5
    } entry_t;

endpackage

// ----- design/pif_front.sv -----
// Front end: accept a field transaction and classify it into a packer entry.
module pif_front (
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic [2:0]           func,
    input  logic signed [32:0]   value,
    input  logic [32:0]          range_size,
    input  logic signed [31:0]   lower_bound,
    input  logic signed [31:0]   upper_bound,
    input  logic                 q_full,
    output logic                 push,
    output pif_pkg::entry_t      entry
);
    import pif_pkg::*;

    // Octets needed for a non-negative magnitude
    function automatic logic [2:0] octet_count(input logic [32:0] m);
        logic [2:0] c;
        if (m < 33'd128)
            c = 3'd1;
        else if (m < 33'd32768)
            c = 3'd2;
        else if (m < 33'd8388608)
            c = 3'd3;
        else
            c = 3'd4;
        return c;
    endfunction

    // Length octet followed by len low octets of v, left-justified
    function automatic logic [BODY_W-1:0] length_and_octets(input logic [2:0] len,
                                                            input logic [31:0] v);
        logic [31:0] vals;
        vals = v << {3'd4 - len, 3'b000};
        return {5'b00000, len, vals};
    endfunction

    // Constrained whole number of offset v within range values
    function automatic entry_t cons_entry(input logic [32:0] range, input logic [31:0] v);
        entry_t     e;
        logic [7:0] rm1;
        logic [3:0] n;
        logic [1:0] k;
        e   = '0;
        rm1 = range[7:0] - 8'd1;
        n   = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (rm1[i])
                n = 4'(i + 1);
        end
        if (v < 32'd256)
            k = 2'd0;
        else if (v < 32'd65536)
            k = 2'd1;
        else if (v < 32'd16777216)
            k = 2'd2;
        else
            k = 2'd3;
        if (range < 33'd2)
        begin
            e = '0;
        end
        else if (range < 33'd256)
        begin
            e.pre     = {1'b0, v[7:0]} & ((9'd1 << n) - 9'd1);
            e.pre_len = n;
        end
        else if (range == 33'd256)
        begin
            e.align  = 1'b1;
            e.body   = {v[7:0], 32'h0};
            e.nbytes = 3'd1;
        end
        else if (range <= 33'd65536)
        begin
            e.align  = 1'b1;
            e.body   = {v[15:0], 24'h0};
            e.nbytes = 3'd2;
        end
        else
        begin
            if (range <= 33'd16777216 && k == 2'd3)
                k = 2'd2;
            e.pre     = {7'b0, k};
            e.pre_len = 4'd2;
            e.align   = 1'b1;
            e.body    = {v << {2'd3 - k, 3'b000}, 8'h00};
            e.nbytes  = {1'b0, k} + 3'd1;
        end
        return e;
    endfunction

    func_t              f;
    logic [31:0]        low;
    logic [32:0]        mag;
    logic [2:0]         len_u;
    logic [2:0]         len_s;
    logic signed [33:0] v34;
    logic signed [33:0] lb34;
    logic signed [33:0] ub34;
    logic signed [33:0] offset;
    logic signed [33:0] ext_range;
    logic               in_range;
    entry_t             cons_e;
    entry_t             ext_e;

    assign item_stall = q_full;
    assign push       = item_valid && !q_full;

    assign f     = func_t'(func);
    assign low   = value[31:0];
    // -value-1 is the bitwise complement
    assign mag   = value[32] ? ~value : value;
    assign len_u = octet_count(mag);
    assign len_s = octet_count({1'b0, low});

    assign v34       = 34'(value);
    assign lb34      = 34'(lower_bound);
    assign ub34      = 34'(upper_bound);
    assign offset    = v34 - lb34;
    assign ext_range = ub34 - lb34 + 34'sd1;
    assign in_range  = (v34 >= lb34) && (v34 <= ub34);

    assign cons_e = cons_entry(range_size, low);
    assign ext_e  = cons_entry(ext_range[32:0], offset[31:0]);

    always_comb
    begin
        entry = '0;
        unique case (f)
            FUNC_BOOL:
            begin
                entry.pre     = {8'h00, (value != 33'sd0)};
                entry.pre_len = 4'd1;
            end
            FUNC_CONS:
            begin
                entry = cons_e;
            end
            FUNC_UNCONS:
            begin
                entry.align  = 1'b1;
                entry.body   = length_and_octets(len_u, low);
                entry.nbytes = len_u + 3'd1;
            end
            FUNC_EXT:
            begin
                if (in_range)
                begin
                    // leading zero bit leaves pre's value unchanged
                    entry         = ext_e;
                    entry.pre_len = ext_e.pre_len + 4'd1;
                end
                else
                begin
                    entry.pre     = 9'd1;
                    entry.pre_len = 4'd1;
                    entry.align   = 1'b1;
                    entry.body    = length_and_octets(len_u, low);
                    entry.nbytes  = len_u + 3'd1;
                end
            end
            FUNC_SEMI:
            begin
                entry.align  = 1'b1;
                entry.body   = length_and_octets(len_s, low);
                entry.nbytes = len_s + 3'd1;
            end
            FUNC_NSMALL:
            begin
                if (low < 32'd64)
                begin
                    entry.pre     = {3'b000, low[5:0]};
                    entry.pre_len = 4'd7;
                end
                else
                begin
                    entry.pre     = 9'd1;
                    entry.pre_len = 4'd1;
                    entry.align   = 1'b1;
                    entry.body    = length_and_octets(len_s, low);
                    entry.nbytes  = len_s + 3'd1;
                end
            end
            FUNC_LENGTH:
            begin
                if (value[32] || (value[31:14] != 18'd0))
                begin
                    entry.err = 1'b1;
                end
                else if (value[13:0] <= 14'd127)
                begin
                    entry.align  = 1'b1;
                    entry.body   = {value[7:0], 32'h0};
                    entry.nbytes = 3'd1;
                end
                else
                begin
                    entry.align  = 1'b1;
                    entry.body   = {2'b10, value[13:0], 24'h0};
                    entry.nbytes = 3'd2;
                end
            end
            FUNC_FLUSH:
            begin
                entry.align = 1'b1;
            end
            default:
            begin
                entry = '0;
            end
        endcase
    end

endmodule

// ----- design/pif_queue.sv -----
// Short queue of classified entries between front end and packer.
module pif_queue #(
    parameter int unsigned DEPTH = pif_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pif_pkg::entry_t wr_entry,
    output logic            full,
    input  logic            pop,
    output pif_pkg::entry_t rd_entry,
    output logic            not_empty
);
    import pif_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    entry_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_entry  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_entry;
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push without pop did not grow queue");
`endif

endmodule

// ----- design/pif_back.sv -----
// Back end: merge entries into the running partial octet and send octets.
module pif_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  pif_pkg::entry_t q_entry,
    output logic            pop,
    output logic            byte_valid,
    input  logic            byte_stall,
    output logic [7:0]      out_byte,
    output logic            last,
    output logic            error
);
    import pif_pkg::*;

    logic [BUF_W-1:0] buf_reg;
    logic [BUF_W-1:0] buf_next;
    logic [2:0]       cnt_reg;
    logic [2:0]       cnt_next;
    logic             err_reg;
    logic             err_next;
    logic [7:0]       part_reg;
    logic [7:0]       part_next;
    logic [2:0]       fill_reg;
    logic [2:0]       fill_next;

    logic             taken;
    logic             can_load;
    logic [4:0]       total;
    logic [4:0]       shamt;
    logic [15:0]      head;
    logic [1:0]       head_bytes;
    logic [BUF_W-1:0] word;
    logic [2:0]       word_cnt;

    assign byte_valid = (cnt_reg != 3'd0);
    assign out_byte   = buf_reg[BUF_W-1 -: 8];
    assign last       = (cnt_reg == 3'd1);
    assign error      = err_reg;

    assign taken    = byte_valid && !byte_stall;
    assign can_load = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && !byte_stall);
    assign pop      = q_valid && can_load;

    // Pending bits, then the leading bit-field, then padding, then octets
    assign total      = 5'(fill_reg) + 5'(q_entry.pre_len);
    assign shamt      = 5'd16 - total;
    assign head       = {part_reg, 8'h00} | (16'(q_entry.pre) << shamt);
    assign head_bytes = q_entry.align ? 2'((total + 5'd7) >> 3) : 2'(total >> 3);
    assign word       = {head, {BODY_W{1'b0}}}
                      | ({q_entry.body, 16'h0000} >> {head_bytes, 3'b000});
    assign word_cnt   = 3'(head_bytes) + q_entry.nbytes;

    always_comb
    begin
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        err_next  = err_reg;
        part_next = part_reg;
        fill_next = fill_reg;
        if (pop)
        begin
            if (q_entry.err)
            begin
                // one flagged zero octet, bit state untouched
                buf_next = '0;
                cnt_next = 3'd1;
                err_next = 1'b1;
            end
            else
            begin
                buf_next = word;
                cnt_next = word_cnt;
                err_next = 1'b0;
                if (q_entry.align)
                begin
                    part_next = 8'h00;
                    fill_next = 3'd0;
                end
                else
                begin
                    fill_next = total[2:0];
                    unique case (head_bytes)
                        2'd0:    part_next = head[15:8];
                        2'd1:    part_next = head[7:0];
                        default: part_next = 8'h00;
                    endcase
                end
            end
        end
        else if (taken)
        begin
            buf_next = buf_reg << 8;
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 3'd0;
            err_reg  <= 1'b0;
            part_reg <= 8'h00;
            fill_reg <= 3'd0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            err_reg  <= err_next;
            part_reg <= part_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd6)
        else $error("more than six octets pending for one transaction");

    a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && error) |-> last)
        else $error("error octet is not the only octet of its transaction");

    a_part_clean: assert property (@(posedge clk) disable iff (!rst_n)
        8'(part_reg << fill_reg) == 8'h00)
        else $error("unused bits of the partial octet are not zero");
`endif

endmodule

// ----- design/per_integer_field_encoder.sv -----
// Top level of the aligned-PER integer field encoder.
// Each field transaction (boolean, constrained, unconstrained, extensible,
// semi-constrained, normally-small, length determinant or flush) is packed
// MSB-first into a running partial octet, and every completed octet leaves
// on the byte channel with last set on the final octet of its transaction.
// A length determinant below zero or of 16384 or more yields one zero octet
// with error and last set and leaves the pending bits untouched. Flush pads
// the pending bits with zeros and sends them if any are pending.
// Timing: the front end classifies a transaction combinationally and writes
// it into a QUEUE_DEPTH-entry queue, so it takes one transaction per cycle
// while the queue has room. The packer pulls a queue entry, then sends its
// octets from its output register at one octet per cycle while byte_stall
// is low; it takes the next entry in the same cycle its last octet is taken.
// A transaction yields 0 to 6 octets. An accepted transaction reaches the
// byte channel through its queue slot and then the packer's output register.
module per_integer_field_encoder #(
    parameter int unsigned QUEUE_DEPTH = pif_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // field transactions
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [2:0]         func,
    input  logic signed [32:0] value,
    input  logic [32:0]        range_size,
    input  logic signed [31:0] lower_bound,
    input  logic signed [31:0] upper_bound,
    // octet transactions
    output logic               byte_valid,
    input  logic               byte_stall,
    output logic [7:0]         out_byte,
    output logic               last,
    output logic               error
);
    import pif_pkg::*;

    logic   q_full;
    logic   push;
    entry_t front_entry;
    logic   q_valid;
    logic   pop;
    entry_t back_entry;

    // Classify: choose field form, octet counts and alignment
    pif_front u_front (
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .func        (func),
        .value       (value),
        .range_size  (range_size),
        .lower_bound (lower_bound),
        .upper_bound (upper_bound),
        .q_full      (q_full),
        .push        (push),
        .entry       (front_entry)
    );

    // Decouple classification from octet output
    pif_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_entry  (front_entry),
        .full      (q_full),
        .pop       (pop),
        .rd_entry  (back_entry),
        .not_empty (q_valid)
    );

    // Pack bits, pad where required, send completed octets
    pif_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_entry    (back_entry),
        .pop        (pop),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .out_byte   (out_byte),
        .last       (last),
        .error      (error)
    );

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the aligned-PER integer field encoder.
`timescale 1ns / 100ps

module testbench;
    import pif_pkg::*;

    // Flow-control modes for the stimulus phases
    typedef enum {
        FLOW_FREE,       // neither side idles
        FLOW_SENDER,     // sender idles at random, 76 percent of the time
        FLOW_RECEIVER,   // receiver stalls at random, 76 percent of the time
        FLOW_BOTH,       // each side idles at random, 38 percent of the time
        FLOW_HOLD        // receiver holds off for a long stretch, sender streams
    } flow_mode_t;

    // One field transaction waiting to be offered to the block
    typedef struct {
        func_t              kind;
        logic signed [32:0] value;
        logic [32:0]        range_size;
        logic signed [31:0] lower_bound;
        logic signed [31:0] upper_bound;
        bit                 drain_first;  // wait until every octet is back
    } field_item_t;

    // One octet the block is expected to send
    typedef struct {
        logic [7:0] octet;
        logic       last;
        logic       error;
    } octet_exp_t;

    localparam int unsigned HOLD_CYCLES    = 150;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned TAIL_CYCLES    = 20;
    localparam int unsigned HOLD_LEAD      = 8;
    localparam longint      INT32_MAX      = 64'sd2147483647;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic               item_stall;
    logic [2:0]         func = FUNC_BOOL;
    logic signed [32:0] value = '0;
    logic [32:0]        range_size = '0;
    logic signed [31:0] lower_bound = '0;
    logic signed [31:0] upper_bound = '0;
    logic               byte_valid;
    logic               byte_stall = 1'b0;
    logic [7:0]         out_byte;
    logic               last;
    logic               error;

    // Stimulus queue filled by the sequence block, drained by the driver
    field_item_t field_q[$];
    // Octets still owed by the block, oldest first
    octet_exp_t  octet_q[$];

    // Predictor state: pending bits of the running octet, MSB first
    bit [7:0]    pend_octet;
    int unsigned pend_count;
    // Octets completed by the transaction being predicted
    bit [7:0]    step_octets[$];

    flow_mode_t  flow_mode = FLOW_FREE;
    int unsigned hold_count;
    int unsigned fail_count;
    int unsigned items_taken;
    int unsigned octets_seen;
    int unsigned errors_seen;
    int unsigned stuck_cycles;
    bit          sender_free;
    field_item_t next_field;
    octet_exp_t  want;

    per_integer_field_encoder uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .func        (func),
        .value       (value),
        .range_size  (range_size),
        .lower_bound (lower_bound),
        .upper_bound (upper_bound),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .out_byte    (out_byte),
        .last        (last),
        .error       (error)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Bit-level predictor
    // ------------------------------------------------------------------

    // Shift the low n bits of v into the running octet, MSB first, and
    // record each octet as soon as it fills up.
    function automatic void shift_bits(logic [31:0] v, int unsigned n);
        for (int i = int'(n) - 1; i >= 0; i--)
        begin
            pend_octet[7 - pend_count] = v[i];
            pend_count++;
            if (pend_count == 8)
            begin
                step_octets.push_back(pend_octet);
                pend_octet = '0;
                pend_count = 0;
            end
        end
    endfunction

    // Zero-pad the running octet to a boundary and release it.
    function automatic void pad_octet();
        if (pend_count != 0)
        begin
            step_octets.push_back(pend_octet);
            pend_octet = '0;
            pend_count = 0;
        end
    endfunction

    function automatic int unsigned octet_span(longint m);
        if (m < 128)
            return 1;
        if (m < 32768)
            return 2;
        if (m < 8388608)
            return 3;
        return 4;
    endfunction

    // Aligned length determinant, short or long form.
    function automatic void encode_length(longint len);
        logic [31:0] word;
        word = 32'(len);
        pad_octet();
        if (len <= 127)
            shift_bits(word, 8);
        else
            shift_bits(word | 32'h8000, 16);
    endfunction

    // Constrained whole number: the field layout follows the range class.
    function automatic void encode_bounded(logic [32:0] span, logic [31:0] v);
        int unsigned n;
        int unsigned k;
        if (span < 2)
            return;
        if (span < 256)
        begin
            n = 0;
            while ((64'd1 << n) < span)
                n++;
            shift_bits(v, n);
        end
        else if (span == 256)
        begin
            pad_octet();
            shift_bits(v, 8);
        end
        else if (span <= 65536)
        begin
            pad_octet();
            shift_bits(v, 16);
        end
        else
        begin
            // Octet count prefix, then the aligned octets; wide ranges allow 4
            k = (v < 256) ? 0 : (v < 65536) ? 1 : (span <= 16777216 || v < 16777216) ? 2 : 3;
            shift_bits(k, 2);
            pad_octet();
            shift_bits(v, 8 * (k + 1));
        end
    endfunction

    function automatic void encode_signed(longint v);
        longint      m;
        int unsigned cnt;
        logic [31:0] word;
        m = (v < 0) ? -(v + 1) : v;
        cnt = octet_span(m);
        word = 32'(v);
        encode_length(cnt);
        shift_bits(word, 8 * cnt);
    endfunction

    function automatic void encode_semi(logic [31:0] v);
        int unsigned cnt;
        cnt = octet_span(longint'({32'b0, v}));
        encode_length(cnt);
        shift_bits(v, 8 * cnt);
    endfunction

    // Work out every octet one field transaction causes and queue them.
    function automatic void predict_octets(field_item_t f);
        longint      v;
        longint      lo;
        longint      hi;
        logic [32:0] span;
        logic [31:0] offset;
        octet_exp_t  e;
        v = f.value;
        lo = f.lower_bound;
        hi = f.upper_bound;
        step_octets.delete();
        case (f.kind)
            FUNC_BOOL:
                shift_bits(32'(v != 0), 1);
            FUNC_CONS:
                encode_bounded(f.range_size, f.value[31:0]);
            FUNC_UNCONS:
                encode_signed(v);
            FUNC_EXT:
                if (v > hi || v < lo)
                begin
                    shift_bits(1, 1);
                    encode_signed(v);
                end
                else
                begin
                    span = 33'(hi - lo + 1);
                    offset = 32'(v - lo);
                    shift_bits(0, 1);
                    encode_bounded(span, offset);
                end
            FUNC_SEMI:
                encode_semi(f.value[31:0]);
            FUNC_NSMALL:
                if (f.value[31:0] < 64)
                begin
                    shift_bits(0, 1);
                    shift_bits(f.value[31:0], 6);
                end
                else
                begin
                    shift_bits(1, 1);
                    encode_semi(f.value[31:0]);
                end
            FUNC_LENGTH:
                if (v < 0 || v >= 16384)
                begin
                    // Oversized length: one flagged zero octet, state untouched
                    e.octet = '0;
                    e.last = 1'b1;
                    e.error = 1'b1;
                    octet_q.push_back(e);
                    return;
                end
                else
                    encode_length(v);
            default:
                pad_octet();
        endcase
        foreach (step_octets[i])
        begin
            e.octet = step_octets[i];
            e.last = (i == step_octets.size() - 1);
            e.error = 1'b0;
            octet_q.push_back(e);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Random value of w bits, w up to 64
    function automatic logic [63:0] rand_bits(int unsigned w);
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return (w == 0) ? 64'd0 : r >> (64 - w);
    endfunction

    // Anywhere in -2^31 .. 2^32-1, magnitudes spread over all widths
    function automatic longint random_value();
        if ($urandom_range(1) == 1)
            return -longint'(rand_bits($urandom_range(31))) - 1;
        return longint'(rand_bits($urandom_range(32)));
    endfunction

    function automatic longint random_bound();
        if ($urandom_range(1) == 1)
            return -longint'(rand_bits($urandom_range(31))) - 1;
        return longint'(rand_bits($urandom_range(31)));
    endfunction

    function automatic logic [32:0] random_span();
        int unsigned w;
        w = $urandom_range(33);
        return (w == 33) ? 33'h1_0000_0000 : 33'(rand_bits(w));
    endfunction

    function automatic field_item_t make_field(func_t k, longint v, longint span,
                                               longint lo, longint hi);
        field_item_t f;
        f.kind = k;
        f.value = 33'(v);
        f.range_size = 33'(span);
        f.lower_bound = 32'(lo);
        f.upper_bound = 32'(hi);
        f.drain_first = 1'b0;
        return f;
    endfunction

    // Mostly well-formed fields of every kind with random content; the rest
    // leave values outside their range, empty bound pairs and bad lengths.
    function automatic field_item_t random_field();
        field_item_t f;
        longint      lo;
        longint      hi;
        int unsigned pick;
        f = make_field(func_t'($urandom_range(7)), random_value(), random_span(),
                       random_bound(), random_bound());
        f.drain_first = ($urandom_range(99) < 3);
        pick = $urandom_range(99);
        case (f.kind)
            FUNC_CONS:
                if (f.range_size != 0 && pick < 90)
                    f.value = 33'(rand_bits(40) % f.range_size);
            FUNC_EXT:
                if (pick >= 10)
                begin
                    lo = f.lower_bound;
                    hi = lo + longint'(rand_bits($urandom_range(32)));
                    if (hi > INT32_MAX)
                        hi = INT32_MAX;
                    f.upper_bound = 32'(hi);
                    if (pick < 85)
                        f.value = 33'(lo + longint'(rand_bits(40) % (hi - lo + 1)));
                end
            FUNC_LENGTH:
                if (pick < 85)
                    f.value = 33'(rand_bits($urandom_range(14)));
            FUNC_NSMALL:
                if (pick < 60)
                    f.value = 33'(rand_bits(6));
            default:
                ;
        endcase
        return f;
    endfunction

    function automatic bit chance(int unsigned percent);
        return $urandom_range(99) < percent;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer queued fields, hold each until the block takes it
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            func <= FUNC_BOOL;
            value <= '0;
            range_size <= '0;
            lower_bound <= '0;
            upper_bound <= '0;
            pend_octet = '0;
            pend_count = 0;
        end
        else
        begin
            // A transaction completes on valid with no stall
            if (item_valid && !item_stall)
                items_taken++;
            sender_free = !item_valid || !item_stall;
            if (sender_free)
            begin
                // Drop valid for a gap, for a drain pause, or when nothing is queued.
                // Predict at the offer: the payload is then fixed until taken.
                if (field_q.size() != 0
                    && !((flow_mode == FLOW_SENDER && chance(76))
                         || (flow_mode == FLOW_BOTH && chance(38)))
                    && !(field_q[0].drain_first && octet_q.size() != 0))
                begin
                    next_field = field_q.pop_front();
                    predict_octets(next_field);
                    func <= next_field.kind;
                    value <= next_field.value;
                    range_size <= next_field.range_size;
                    lower_bound <= next_field.lower_bound;
                    upper_bound <= next_field.upper_bound;
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall: random per mode, plus one long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_stall <= 1'b0;
            hold_count <= 0;
        end
        else if (flow_mode == FLOW_HOLD && hold_count < HOLD_CYCLES)
        begin
            // Hold off while the sender keeps streaming, so the block backs up
            byte_stall <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
            byte_stall <= (flow_mode == FLOW_RECEIVER && chance(76))
                          || (flow_mode == FLOW_BOTH && chance(38));
    end

    // ------------------------------------------------------------------
    // Monitor: compare each octet with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && byte_valid === 1'b1 && byte_stall === 1'b0)
        begin
            octets_seen++;
            if (error === 1'b1)
                errors_seen++;
            if (octet_q.size() == 0)
            begin
                $error("unexpected octet %h (last %b, error %b)", out_byte, last, error);
                fail_count++;
            end
            else
            begin
                want = octet_q.pop_front();
                if (out_byte !== want.octet)
                begin
                    $error("out_byte: expected %h, got %h", want.octet, out_byte);
                    fail_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, last);
                    fail_count++;
                end
                if (error !== want.error)
                begin
                    $error("error: expected %b, got %b", want.error, error);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (byte_valid === 1'b1 && !byte_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: directed fields, then random phases under each flow mode
    // ------------------------------------------------------------------
    task automatic run_phase(flow_mode_t mode, int unsigned count);
        field_item_t f;
        // Let the previous phase go out before switching the flow mode
        while (field_q.size() != 0)
            @(negedge clk);
        flow_mode = mode;
        for (int i = 0; i < count; i++)
        begin
            f = random_field();
            // The hold-off phase streams from its start so the block backs up;
            // every other phase opens with the sender paused until the block is empty
            if (mode == FLOW_HOLD)
            begin
                if (i < HOLD_LEAD)
                    f.drain_first = 1'b0;
            end
            else if (i == 0)
                f.drain_first = 1'b1;
            field_q.push_back(f);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Boolean both ways, constrained at every range class edge
        field_q.push_back(make_field(FUNC_BOOL, -64'sd2147483648, 0, 0, 0));
        field_q.push_back(make_field(FUNC_BOOL, 0, 0, 0, 0));
        field_q.push_back(make_field(FUNC_CONS, 0, 0, 0, 0));
        field_q.push_back(make_field(FUNC_CONS, 1, 2, 0, 0));
        field_q.push_back(make_field(FUNC_CONS, 254, 255, 0, 0));
        field_q.push_back(make_field(FUNC_CONS, 171, 256, 0, 0));
        field_q.push_back(make_field(FUNC_CONS, 65535, 65536, 0, 0));
        field_q.push_back(make_field(FUNC_CONS, 16777215, 16777216, 0, 0));
        field_q.push_back(make_field(FUNC_CONS, 64'd4294967295, 64'd4294967296, 0, 0));
        // Value wider than its field: only the low bits go out
        field_q.push_back(make_field(FUNC_CONS, 64'd4294967295, 5, 0, 0));
        // Unconstrained at the octet-count edges and beyond the 32-bit range
        field_q.push_back(make_field(FUNC_UNCONS, -64'sd2147483648, 0, 0, 0));
        field_q.push_back(make_field(FUNC_UNCONS, 64'd4294967295, 0, 0, 0));
        field_q.push_back(make_field(FUNC_UNCONS, 128, 0, 0, 0));
        field_q.push_back(make_field(FUNC_UNCONS, -129, 0, 0, 0));
        // Extensible: inside, outside, empty bound pair, full 32-bit range
        field_q.push_back(make_field(FUNC_EXT, 7, 0, -5, 300));
        field_q.push_back(make_field(FUNC_EXT, 25, 0, 10, 20));
        field_q.push_back(make_field(FUNC_EXT, 15, 0, 20, 10));
        field_q.push_back(make_field(FUNC_EXT, INT32_MAX, 0, -64'sd2147483648, INT32_MAX));
        field_q.push_back(make_field(FUNC_SEMI, -1, 0, 0, 0));
        field_q.push_back(make_field(FUNC_SEMI, 8388608, 0, 0, 0));
        field_q.push_back(make_field(FUNC_NSMALL, 63, 0, 0, 0));
        field_q.push_back(make_field(FUNC_NSMALL, 64, 0, 0, 0));
        // Length determinant: both forms and both oversized cases
        field_q.push_back(make_field(FUNC_LENGTH, 127, 0, 0, 0));
        field_q.push_back(make_field(FUNC_LENGTH, 16383, 0, 0, 0));
        field_q.push_back(make_field(FUNC_LENGTH, 16384, 0, 0, 0));
        field_q.push_back(make_field(FUNC_LENGTH, -1, 0, 0, 0));
        field_q.push_back(make_field(FUNC_FLUSH, 0, 0, 0, 0));

        run_phase(FLOW_FREE, 110);
        run_phase(FLOW_SENDER, 90);
        run_phase(FLOW_RECEIVER, 90);
        run_phase(FLOW_BOTH, 90);
        run_phase(FLOW_HOLD, 60);

        // Wait for the last field to be taken and every octet to come back
        while (field_q.size() != 0 || item_valid || octet_q.size() != 0)
            @(negedge clk);
        flow_mode = FLOW_FREE;
        // Catch any stray octet after the stream has drained
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Run covered %0d field transactions of all eight kinds and %0d octets",
                 items_taken, octets_seen);
        $display("(%0d flagged lengths) under free flow, gaps, stalls and a long hold-off.",
                 errors_seen);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sim.f -----
design/pif_pkg.sv
design/pif_front.sv
design/pif_queue.sv
design/pif_back.sv
design/per_integer_field_encoder.sv
verif/testbench.sv
